@@ rtl/edit_distance_similarity_unit_assert.svh @@
// Assertion macros used by the port-level checker
`ifndef EDIT_DISTANCE_SIMILARITY_UNIT_ASSERT_SVH
`define EDIT_DISTANCE_SIMILARITY_UNIT_ASSERT_SVH

// clocked implication, disabled in reset
`define EDS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define EDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/eds_pkg.sv @@
// Shared constants and types for the edit distance similarity unit
package eds_pkg;
    localparam int MAX_LEN = 256;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int COST_W  = LEN_W;
    localparam int COL_W   = $clog2(MAX_LEN + 1);
    localparam int DIST_W  = 9;
    localparam int SIM_W   = 17;
    localparam int Q_W     = 16;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;

    typedef enum logic [1:0] {
        MODE_APPEND_A = 2'd0,
        MODE_APPEND_B = 2'd1,
        MODE_COMPUTE  = 2'd2,
        MODE_NONE     = 2'd3
    } mode_t;

    // compute job handed from front to back
    typedef struct packed {
        logic [LEN_W-1:0] len_a;
        logic [LEN_W-1:0] len_b;
        logic             too_long;
    } job_t;
endpackage

@@ rtl/eds_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read
module eds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/eds_front.sv @@
// Front end: takes items, writes characters, queues compute jobs
module eds_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [1:0]                mode,
    input  logic [7:0]                char_byte,
    output logic                      busy,
    output logic                      wa_en,
    output logic                      wb_en,
    output logic [eds_pkg::ADDR_W-1:0] waddr,
    output logic [7:0]                wdata,
    output logic                      job_valid,
    output eds_pkg::job_t             job,
    input  logic                      job_pop
);
    logic [eds_pkg::LEN_W-1:0]  len_a_reg, len_b_reg;
    logic                       ovf_reg;
    eds_pkg::job_t              q_reg [eds_pkg::QDEPTH];
    logic [eds_pkg::QPTR_W-1:0] wp_reg, rp_reg;
    logic [eds_pkg::QPTR_W:0]   cnt_reg;
    logic                       acc, push, full_a, full_b;

    // one compute at a time: stall while a job waits or runs
    assign busy   = (cnt_reg != '0);

    assign acc    = start && !busy;
    assign full_a = (len_a_reg == eds_pkg::LEN_W'(eds_pkg::MAX_LEN));
    assign full_b = (len_b_reg == eds_pkg::LEN_W'(eds_pkg::MAX_LEN));
    assign push   = acc && (eds_pkg::mode_t'(mode) == eds_pkg::MODE_COMPUTE);
    assign wa_en  = acc && (eds_pkg::mode_t'(mode) == eds_pkg::MODE_APPEND_A) && !full_a;
    assign wb_en  = acc && (eds_pkg::mode_t'(mode) == eds_pkg::MODE_APPEND_B) && !full_b;
    assign waddr  = wa_en ? len_a_reg[eds_pkg::ADDR_W-1:0] : len_b_reg[eds_pkg::ADDR_W-1:0];
    assign wdata  = char_byte;
    assign job_valid = (cnt_reg != '0);
    assign job    = q_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg <= '0;
            len_b_reg <= '0;
            ovf_reg   <= 1'b0;
            wp_reg    <= '0;
            rp_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (wa_en)
            begin
                len_a_reg <= len_a_reg + 1'b1;
            end
            if (wb_en)
            begin
                len_b_reg <= len_b_reg + 1'b1;
            end
            if (acc && ((eds_pkg::mode_t'(mode) == eds_pkg::MODE_APPEND_A && full_a) ||
                        (eds_pkg::mode_t'(mode) == eds_pkg::MODE_APPEND_B && full_b)))
            begin
                ovf_reg <= 1'b1;
            end
            if (push)
            begin
                q_reg[wp_reg] <= '{len_a: len_a_reg, len_b: len_b_reg, too_long: ovf_reg};
                wp_reg    <= wp_reg + 1'b1;
                len_a_reg <= '0;
                len_b_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            if (job_pop && job_valid)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (eds_pkg::QPTR_W+1)'(push)
                       - (eds_pkg::QPTR_W+1)'(job_pop && job_valid);
        end
    end
endmodule

@@ rtl/eds_back.sv @@
// Back end: rolling-row Levenshtein sweep and restoring divider
module eds_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       job_valid,
    input  eds_pkg::job_t              job,
    output logic                       job_pop,
    output logic [eds_pkg::ADDR_W-1:0] ra_addr,
    input  logic [7:0]                 ra_data,
    output logic [eds_pkg::ADDR_W-1:0] rb_addr,
    input  logic [7:0]                 rb_data,
    output logic                       done,
    output logic [eds_pkg::DIST_W-1:0] distance,
    output logic [eds_pkg::SIM_W-1:0]  similarity,
    output logic                       both_empty,
    output logic                       too_long
);
    localparam int CW = eds_pkg::COST_W;
    localparam int LW = eds_pkg::LEN_W;
    localparam int CD = eds_pkg::MAX_LEN + 1;
    localparam int CA = $clog2(CD);
    localparam int NW = CW + eds_pkg::Q_W;

    typedef enum logic [2:0] {
        S_IDLE, S_INIT, S_ROWSTART, S_CELL_RD, S_CELL, S_DIV, S_OUT
    } state_t;

    state_t            state_reg;
    eds_pkg::job_t     job_reg;
    logic [LW-1:0]     i_reg, j_reg;
    logic [CW-1:0]     diag_reg, left_reg, dist_reg;
    logic [NW-1:0]     num_reg;
    logic [LW:0]       rem_reg;
    logic [NW-1:0]     quo_reg;
    logic [$clog2(NW+1)-1:0] bit_reg;
    logic              c_we;
    logic [CA-1:0]     c_waddr, c_raddr;
    logic [CW-1:0]     c_wdata, c_rdata, cell_cost, m;
    logic [LW-1:0]     maxlen;
    logic [LW:0]       trial;

    eds_ram #(.WIDTH(CW), .DEPTH(CD)) u_cost (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    assign maxlen = (job_reg.len_a > job_reg.len_b) ? job_reg.len_a : job_reg.len_b;
    assign ra_addr = eds_pkg::ADDR_W'(i_reg - 1'b1);
    // column j+1 needs B[j]; a row start fetches B[0] for column 1
    assign rb_addr = (state_reg == S_CELL_RD) ? eds_pkg::ADDR_W'(j_reg) : '0;
    assign job_pop = (state_reg == S_OUT);

    // cost cell: up comes from the row RAM, left and diag are held
    always_comb
    begin
        m = (left_reg < c_rdata) ? left_reg : c_rdata;
        m = (m < diag_reg) ? m : diag_reg;
        cell_cost = (ra_data == rb_data) ? diag_reg : CW'(m + 1'b1);
    end

    always_comb
    begin
        c_we    = 1'b0;
        c_waddr = CA'(j_reg);
        c_wdata = CW'(j_reg);
        c_raddr = CA'(j_reg);
        case (state_reg)
            S_INIT:     c_we = 1'b1;
            S_ROWSTART:
            begin
                c_we = 1'b1;
                c_waddr = '0;
                c_wdata = CW'(i_reg);
                c_raddr = CA'(1);
            end
            S_CELL:
            begin
                c_we = 1'b1;
                c_wdata = cell_cost;
            end
            S_CELL_RD:
            begin
                // up value of the next column, or the final cost at row end
                c_raddr = (j_reg >= job_reg.len_b) ? CA'(job_reg.len_b) : CA'(j_reg + 1'b1);
            end
            default: c_we = 1'b0;
        endcase
        if (state_reg == S_DIV || state_reg == S_OUT)
        begin
            c_raddr = CA'(job_reg.len_b);
        end
    end

    assign trial = {rem_reg[LW-1:0], num_reg[NW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg   <= job;
                        j_reg     <= '0;
                        state_reg <= S_INIT;
                    end
                end
                S_INIT:
                begin
                    if (j_reg == job_reg.len_b)
                    begin
                        i_reg     <= LW'(1);
                        state_reg <= (job_reg.len_a == '0) ? S_CELL_RD : S_ROWSTART;
                        j_reg     <= job_reg.len_b;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_ROWSTART:
                begin
                    diag_reg <= CW'(i_reg - 1'b1);
                    left_reg <= CW'(i_reg);
                    j_reg    <= LW'(1);
                    state_reg <= (job_reg.len_b == '0) ? S_CELL_RD : S_CELL;
                end
                S_CELL:
                begin
                    diag_reg <= c_rdata;
                    left_reg <= cell_cost;
                    state_reg <= S_CELL_RD;
                end
                S_CELL_RD:
                begin
                    // next column, next row or on to the divide, then wait one read
                    if (i_reg > job_reg.len_a ||
                        (j_reg >= job_reg.len_b && i_reg == job_reg.len_a))
                    begin
                        j_reg <= job_reg.len_b;
                        state_reg <= S_DIV;
                        bit_reg <= '0;
                        rem_reg <= '0;
                        quo_reg <= '0;
                        num_reg <= '0;
                    end
                    else if (j_reg >= job_reg.len_b)
                    begin
                        i_reg <= i_reg + 1'b1;
                        state_reg <= S_ROWSTART;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                        state_reg <= S_CELL;
                    end
                end
                S_DIV:
                begin
                    if (bit_reg == '0)
                    begin
                        dist_reg <= c_rdata;
                        num_reg  <= {c_rdata, {eds_pkg::Q_W{1'b0}}};
                        bit_reg  <= bit_reg + 1'b1;
                    end
                    else if (maxlen == '0)
                    begin
                        dist_reg <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        num_reg <= num_reg << 1;
                        if (trial >= {1'b0, maxlen})
                        begin
                            rem_reg <= trial - {1'b0, maxlen};
                            quo_reg <= {quo_reg[NW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= trial;
                            quo_reg <= {quo_reg[NW-2:0], 1'b0};
                        end
                        if (bit_reg == ($clog2(NW+1))'(NW))
                        begin
                            state_reg <= S_OUT;
                        end
                        bit_reg <= bit_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    done       <= 1'b1;
                    distance   <= eds_pkg::DIST_W'(dist_reg);
                    both_empty <= (maxlen == '0);
                    too_long   <= job_reg.too_long;
                    similarity <= (maxlen == '0) ? eds_pkg::SIM_W'(1 << eds_pkg::Q_W) :
                                  eds_pkg::SIM_W'((NW+1)'(1 << eds_pkg::Q_W) - {1'b0, quo_reg});
                    state_reg  <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/edit_distance_similarity_unit.sv @@
// Top level of the edit distance similarity unit
// Usage:
//   Drive start with mode and char_byte; the item transfers on a clock edge
//   where start is high and busy is low.
//   Modes 0 and 1 append char_byte to string A or B, one per cycle while busy is low.
//   Mode 2 queues a compute; busy stays high until its result is out.
//   Mode 3 is taken and ignored.
//   The result appears on distance, similarity, both_empty and too_long for
//   one cycle with done high; the receiver must take it then.
// Sequence of a compute, from its transfer to done:
//   row init (row 0 of the cost-row RAM), then the cost sweep (a row start
//   then one write and one read wait per cell), a bit-serial divide and the output state.
//   The registered read of the cost-row RAM is why each cell needs a read wait.
// Appends are taken every cycle while no compute is pending.
// Reset clears lengths, the overflow flag, the job queue and the sequencer;
// string and cost-row memories are not cleared and need no clearing pass.
module edit_distance_similarity_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [7:0]  char_byte,
    output logic        done,
    output logic [8:0]  distance,
    output logic [16:0] similarity,
    output logic        both_empty,
    output logic        too_long
);
    logic                       wa_en, wb_en, job_valid, job_pop;
    logic [eds_pkg::ADDR_W-1:0] waddr, ra_addr, rb_addr;
    logic [7:0]                 wdata, ra_data, rb_data;
    eds_pkg::job_t              job;

    eds_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .mode(mode),
        .char_byte(char_byte), .busy(busy), .wa_en(wa_en), .wb_en(wb_en),
        .waddr(waddr), .wdata(wdata), .job_valid(job_valid), .job(job),
        .job_pop(job_pop)
    );

    eds_ram #(.WIDTH(8), .DEPTH(eds_pkg::MAX_LEN)) u_str_a (
        .clk(clk), .we(wa_en), .waddr(waddr), .wdata(wdata),
        .raddr(ra_addr), .rdata(ra_data)
    );

    eds_ram #(.WIDTH(8), .DEPTH(eds_pkg::MAX_LEN)) u_str_b (
        .clk(clk), .we(wb_en), .waddr(waddr), .wdata(wdata),
        .raddr(rb_addr), .rdata(rb_data)
    );

    eds_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job(job),
        .job_pop(job_pop), .ra_addr(ra_addr), .ra_data(ra_data),
        .rb_addr(rb_addr), .rb_data(rb_data), .done(done),
        .distance(distance), .similarity(similarity),
        .both_empty(both_empty), .too_long(too_long)
    );
endmodule

@@ rtl/eds_checker.sv @@
// Port-level checker for the edit distance similarity unit
`include "edit_distance_similarity_unit_assert.svh"
module eds_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  mode,
    input logic        done,
    input logic [8:0]  distance,
    input logic [16:0] similarity,
    input logic        both_empty
);
    logic compute_xfer, empty_ok;

    assign compute_xfer = start && !busy && (eds_pkg::mode_t'(mode) == eds_pkg::MODE_COMPUTE);
    assign empty_ok     = (similarity == 17'h10000) && (distance == 9'd0);

    `EDS_ASSERT_IMPL(a_empty_sim, clk, rst_n, done && both_empty, empty_ok, "empty pair not one")
    `EDS_ASSERT_IMPL(a_sim_range, clk, rst_n, done, similarity <= 17'h10000, "similarity above one")
    `EDS_ASSERT_NEXT(a_compute_busy, clk, rst_n, compute_xfer, busy, "compute must raise busy")
    `EDS_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "result strobe longer than a cycle")
endmodule

bind edit_distance_similarity_unit eds_checker u_eds_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
    .done(done), .distance(distance), .similarity(similarity),
    .both_empty(both_empty)
);
